// ----- rtl/dgcc_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants, types and state codes for the directed graph cycle check.
// No dependencies.
package dgcc_pkg;

    // default sizes of the graph stores
    localparam int MAX_VERTICES_DEF = 256;
    localparam int MAX_EDGES_DEF    = 1024;

    // fixed field widths at the ports
    localparam int CMD_W    = 2;
    localparam int VTX_W    = 8;
    localparam int VCOUNT_W = 9;
    localparam int STATUS_W = 2;
    localparam int EDGES_W  = 11;

    localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 9'd256;

    // command codes
    localparam logic [CMD_W-1:0] CMD_ADD   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CHECK = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

    typedef enum logic [3:0] {
        WK_IDLE,
        WK_HCLR,
        WK_MCLR,
        WK_START,
        WK_SEEN,
        WK_ROOT,
        WK_EDGE,
        WK_ERD,
        WK_MRD,
        WK_POP,
        WK_PUSH,
        WK_DONE
    } walk_state_t;

    typedef struct packed {
        logic busy;
        logic done;
        logic found;
    } walk_stat_t;

    typedef struct packed {
        logic range_err;
        logic full_err;
    } load_err_t;

endpackage

// ----- rtl/directed_graph_cycle_check_top.sv -----
`timescale 1ns / 1ps
// Top level of the directed graph cycle check: config register, edge stores, result regs.
// Depends on dgcc_pkg, dgcc_ram, dgcc_load and dgcc_walk.
//
//  channel   | handshake             | word
//  ----------+-----------------------+------------------------------------------
//  command   | start && !busy        | command, source_vertex, target_vertex
//  result    | done (one-cycle pulse)| has_cycle, status, edges_held
//  config    | cfg_we                | cfg_wdata (vertex_count)
//
// Add edge: one word per cycle while not busy, two-stage head read and link write with
// forwarding. Check (n = active vertex count): mark sweep, a mark read per root tried
// (and a head read if it starts a search), an edge read per edge walked (and a mark
// read unless its target is out of range), a push per new vertex, a pop per vertex left
// (none for a root), then done. Clear, reset: busy while MAX_VERTICES heads are emptied.
// Results are shown for one cycle only; the receiver cannot stall.
module directed_graph_cycle_check_top import dgcc_pkg::*; #(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF,
    parameter int MAX_EDGES    = MAX_EDGES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [CMD_W-1:0]    command,
    input  logic [VTX_W-1:0]    source_vertex,
    input  logic [VTX_W-1:0]    target_vertex,
    input  logic                cfg_we,
    input  logic [VCOUNT_W-1:0] cfg_wdata,
    output logic                done,
    output logic                has_cycle,
    output logic [STATUS_W-1:0] status,
    output logic [EDGES_W-1:0]  edges_held
);

    localparam int VW = $clog2(MAX_VERTICES);
    localparam int NW = $clog2(MAX_VERTICES + 1);
    localparam int EW = $clog2(MAX_EDGES + 1);
    localparam int AW = $clog2(MAX_EDGES);
    localparam int CW = (NW > VCOUNT_W) ? NW : VCOUNT_W;

    logic [VCOUNT_W-1:0] vcount_reg;
    logic                done_reg;
    logic                has_cycle_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [EDGES_W-1:0]  edges_held_reg;

    logic [CW-1:0] vc_wide;
    logic [NW-1:0] n_act;
    logic          accept;
    logic          add_go;
    logic          check_go;
    logic          clear_go;

    walk_stat_t    wstat;
    load_err_t     lerr;
    logic [EW-1:0] stored;

    logic          ld_head_we, wk_head_we;
    logic [VW-1:0] ld_head_waddr, wk_head_waddr;
    logic [EW-1:0] ld_head_wdata, wk_head_wdata;
    logic [VW-1:0] ld_head_raddr, wk_head_raddr;
    logic          head_we;
    logic [VW-1:0] head_waddr;
    logic [EW-1:0] head_wdata;
    logic [VW-1:0] head_raddr;
    logic [EW-1:0] head_rdata;

    logic             edge_we;
    logic [AW-1:0]    edge_waddr;
    logic [VW+EW-1:0] edge_wdata;
    logic [AW-1:0]    edge_raddr;
    logic [VW+EW-1:0] edge_rdata;

    assign vc_wide = CW'(vcount_reg);
    assign n_act   = (vc_wide > CW'(MAX_VERTICES)) ? NW'(MAX_VERTICES) : NW'(vc_wide);

    assign busy     = wstat.busy;
    assign accept   = start && !wstat.busy;
    assign add_go   = accept && (command == CMD_ADD);
    assign check_go = accept && (command == CMD_CHECK);
    assign clear_go = accept && (command == CMD_CLEAR);

    // loader owns the head port while idle, the sequencer while busy
    assign head_we    = ld_head_we || wk_head_we;
    assign head_waddr = wk_head_we ? wk_head_waddr : ld_head_waddr;
    assign head_wdata = wk_head_we ? wk_head_wdata : ld_head_wdata;
    assign head_raddr = wstat.busy ? wk_head_raddr : ld_head_raddr;

    dgcc_ram #(.WIDTH(EW), .DEPTH(MAX_VERTICES)) u_head_ram (
        .clk   (clk),
        .we    (head_we),
        .waddr (head_waddr),
        .wdata (head_wdata),
        .raddr (head_raddr),
        .rdata (head_rdata)
    );

    dgcc_ram #(.WIDTH(VW + EW), .DEPTH(MAX_EDGES)) u_edge_ram (
        .clk   (clk),
        .we    (edge_we),
        .waddr (edge_waddr),
        .wdata (edge_wdata),
        .raddr (edge_raddr),
        .rdata (edge_rdata)
    );

    dgcc_load #(.MAX_VERTICES(MAX_VERTICES), .MAX_EDGES(MAX_EDGES)) u_load (
        .clk        (clk),
        .rst_n      (rst_n),
        .add_go     (add_go),
        .clear_go   (clear_go),
        .src        (source_vertex),
        .dst        (target_vertex),
        .n          (n_act),
        .head_raddr (ld_head_raddr),
        .head_rdata (head_rdata),
        .head_we    (ld_head_we),
        .head_waddr (ld_head_waddr),
        .head_wdata (ld_head_wdata),
        .edge_we    (edge_we),
        .edge_waddr (edge_waddr),
        .edge_wdata (edge_wdata),
        .stored     (stored),
        .err        (lerr)
    );

    dgcc_walk #(.MAX_VERTICES(MAX_VERTICES), .MAX_EDGES(MAX_EDGES)) u_walk (
        .clk        (clk),
        .rst_n      (rst_n),
        .check_go   (check_go),
        .clear_go   (clear_go),
        .n          (n_act),
        .head_raddr (wk_head_raddr),
        .head_rdata (head_rdata),
        .head_we    (wk_head_we),
        .head_waddr (wk_head_waddr),
        .head_wdata (wk_head_wdata),
        .edge_raddr (edge_raddr),
        .edge_rdata (edge_rdata),
        .stat       (wstat)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcount_reg <= VCOUNT_RESET;
            done_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                vcount_reg <= cfg_wdata;
            end
            done_reg <= wstat.done;
        end
    end

    always_ff @(posedge clk)
    begin
        has_cycle_reg  <= wstat.found;
        status_reg     <= lerr.range_err ? ST_RANGE : (lerr.full_err ? ST_FULL : ST_OK);
        edges_held_reg <= EDGES_W'(stored);
    end

    assign done       = done_reg;
    assign has_cycle  = has_cycle_reg;
    assign status     = status_reg;
    assign edges_held = edges_held_reg;

`ifndef SYNTHESIS
    a_head_port: assert property (@(posedge clk) disable iff (!rst_n)
        !(ld_head_we && wk_head_we))
        else $error("head store written by loader and sequencer together");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result word without a preceding check");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result word shown for more than one cycle");
`endif

endmodule

// ----- rtl/dgcc_ram.sv -----
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module dgcc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/dgcc_load.sv -----
`timescale 1ns / 1ps
// Edge loader: two-stage head read / link write, edge count and error flags.
// Depends on dgcc_pkg.
module dgcc_load import dgcc_pkg::*; #(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF,
    parameter int MAX_EDGES    = MAX_EDGES_DEF,
    localparam int VW = $clog2(MAX_VERTICES),
    localparam int NW = $clog2(MAX_VERTICES + 1),
    localparam int EW = $clog2(MAX_EDGES + 1),
    localparam int AW = $clog2(MAX_EDGES)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              add_go,
    input  logic              clear_go,
    input  logic [VTX_W-1:0]  src,
    input  logic [VTX_W-1:0]  dst,
    input  logic [NW-1:0]     n,
    output logic [VW-1:0]     head_raddr,
    input  logic [EW-1:0]     head_rdata,
    output logic              head_we,
    output logic [VW-1:0]     head_waddr,
    output logic [EW-1:0]     head_wdata,
    output logic              edge_we,
    output logic [AW-1:0]     edge_waddr,
    output logic [VW+EW-1:0]  edge_wdata,
    output logic [EW-1:0]     stored,
    output load_err_t         err
);

    localparam int SW = (NW > VTX_W) ? NW : VTX_W;

    logic             p_valid_reg, p_valid_next;
    logic [EW-1:0]    stored_reg, stored_next;
    load_err_t        err_reg, err_next;
    logic             fwd_reg, fwd_next;
    logic [VTX_W-1:0] p_src_reg;
    logic [VTX_W-1:0] p_dst_reg;
    logic             p_bad_reg;
    logic [EW-1:0]    fwd_val_reg;

    logic          range_bad;
    logic          full;
    logic          p_store;
    logic [EW-1:0] head_val;

    assign range_bad = (SW'(src) >= SW'(n)) || (SW'(dst) >= SW'(n));
    assign full      = stored_reg >= EW'(MAX_EDGES);
    assign p_store   = p_valid_reg && !p_bad_reg && !full;

    // a back-to-back add on the same source sees the index written this cycle
    assign head_val  = fwd_reg ? fwd_val_reg : head_rdata;

    assign head_raddr = VW'(src);
    assign head_we    = p_store;
    assign head_waddr = VW'(p_src_reg);
    assign head_wdata = stored_reg;
    assign edge_we    = p_store;
    assign edge_waddr = AW'(stored_reg);
    assign edge_wdata = {VW'(p_dst_reg), head_val};

    always_comb
    begin
        p_valid_next = add_go;
        fwd_next     = add_go && p_store && (p_src_reg == src);
        stored_next  = stored_reg;
        err_next     = err_reg;
        if (clear_go)
        begin
            stored_next = '0;
            err_next    = '0;
        end
        else if (p_valid_reg)
        begin
            if (p_bad_reg)
            begin
                err_next.range_err = 1'b1;
            end
            else if (full)
            begin
                err_next.full_err = 1'b1;
            end
            else
            begin
                stored_next = stored_reg + EW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
            stored_reg  <= '0;
            err_reg     <= '0;
            fwd_reg     <= 1'b0;
        end
        else
        begin
            p_valid_reg <= p_valid_next;
            stored_reg  <= stored_next;
            err_reg     <= err_next;
            fwd_reg     <= fwd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (add_go)
        begin
            p_src_reg <= src;
            p_dst_reg <= dst;
            p_bad_reg <= range_bad;
        end
        fwd_val_reg <= stored_reg;
    end

    assign stored = stored_reg;
    assign err    = err_reg;

endmodule

// ----- rtl/dgcc_walk.sv -----
`timescale 1ns / 1ps
// Depth-first search sequencer with mark and stack RAMs; also sweeps list heads.
// Depends on dgcc_pkg and dgcc_ram.
module dgcc_walk import dgcc_pkg::*; #(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF,
    parameter int MAX_EDGES    = MAX_EDGES_DEF,
    localparam int VW = $clog2(MAX_VERTICES),
    localparam int NW = $clog2(MAX_VERTICES + 1),
    localparam int EW = $clog2(MAX_EDGES + 1),
    localparam int AW = $clog2(MAX_EDGES)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             check_go,
    input  logic             clear_go,
    input  logic [NW-1:0]    n,
    output logic [VW-1:0]    head_raddr,
    input  logic [EW-1:0]    head_rdata,
    output logic             head_we,
    output logic [VW-1:0]    head_waddr,
    output logic [EW-1:0]    head_wdata,
    output logic [AW-1:0]    edge_raddr,
    input  logic [VW+EW-1:0] edge_rdata,
    output walk_stat_t       stat
);

    walk_state_t   state_reg, state_next;
    logic [NW-1:0] cnt_reg, cnt_next;
    logic [NW-1:0] depth_reg, depth_next;
    logic          found_reg, found_next;
    logic [VW-1:0] top_v_reg, top_v_next;
    logic [EW-1:0] top_c_reg, top_c_next;
    logic [VW-1:0] t_reg, t_next;

    // marks: bit 1 seen, bit 0 on path
    logic          mark_we;
    logic [VW-1:0] mark_waddr;
    logic [1:0]    mark_wdata;
    logic [VW-1:0] mark_raddr;
    logic [1:0]    mark_rdata;

    logic             stk_we;
    logic [VW-1:0]    stk_waddr;
    logic [VW+EW-1:0] stk_wdata;
    logic [VW-1:0]    stk_raddr;
    logic [VW+EW-1:0] stk_rdata;

    logic [VW-1:0] e_target;
    logic [EW-1:0] e_link;
    logic          top_nil;

    assign e_target = edge_rdata[VW+EW-1:EW];
    assign e_link   = edge_rdata[EW-1:0];
    assign top_nil  = top_c_reg >= EW'(MAX_EDGES);

    dgcc_ram #(.WIDTH(2), .DEPTH(MAX_VERTICES)) u_mark_ram (
        .clk   (clk),
        .we    (mark_we),
        .waddr (mark_waddr),
        .wdata (mark_wdata),
        .raddr (mark_raddr),
        .rdata (mark_rdata)
    );

    dgcc_ram #(.WIDTH(VW + EW), .DEPTH(MAX_VERTICES)) u_stack_ram (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            WK_IDLE:
            begin
                if (clear_go)
                begin
                    state_next = WK_HCLR;
                end
                else if (check_go)
                begin
                    state_next = WK_MCLR;
                end
            end
            WK_HCLR:
            begin
                if (cnt_reg == NW'(MAX_VERTICES - 1))
                begin
                    state_next = WK_IDLE;
                end
            end
            WK_MCLR:
            begin
                if (cnt_reg >= n)
                begin
                    state_next = WK_START;
                end
            end
            WK_START:
            begin
                state_next = (cnt_reg >= n) ? WK_DONE : WK_SEEN;
            end
            WK_SEEN:
            begin
                state_next = mark_rdata[1] ? WK_START : WK_ROOT;
            end
            WK_ROOT:
            begin
                state_next = WK_EDGE;
            end
            WK_EDGE:
            begin
                if (!top_nil)
                begin
                    state_next = WK_ERD;
                end
                else if (depth_reg == NW'(1))
                begin
                    state_next = WK_START;
                end
                else
                begin
                    state_next = WK_POP;
                end
            end
            WK_ERD:
            begin
                state_next = (NW'(e_target) >= n) ? WK_EDGE : WK_MRD;
            end
            WK_MRD:
            begin
                if (!mark_rdata[1])
                begin
                    state_next = (depth_reg >= NW'(MAX_VERTICES)) ? WK_EDGE : WK_PUSH;
                end
                else if (mark_rdata[0])
                begin
                    state_next = WK_DONE;
                end
                else
                begin
                    state_next = WK_EDGE;
                end
            end
            WK_POP:
            begin
                state_next = WK_EDGE;
            end
            WK_PUSH:
            begin
                state_next = WK_EDGE;
            end
            WK_DONE:
            begin
                state_next = WK_IDLE;
            end
            default:
            begin
                state_next = WK_IDLE;
            end
        endcase
    end

    // outputs, memory controls and datapath
    always_comb
    begin
        cnt_next   = cnt_reg;
        depth_next = depth_reg;
        found_next = found_reg;
        top_v_next = top_v_reg;
        top_c_next = top_c_reg;
        t_next     = t_reg;
        head_raddr = VW'(cnt_reg);
        head_we    = 1'b0;
        head_waddr = VW'(cnt_reg);
        head_wdata = EW'(MAX_EDGES);
        edge_raddr = AW'(top_c_reg);
        mark_we    = 1'b0;
        mark_waddr = VW'(cnt_reg);
        mark_wdata = 2'b00;
        mark_raddr = VW'(cnt_reg);
        stk_we     = 1'b0;
        stk_waddr  = VW'(depth_reg - NW'(1));
        stk_wdata  = {top_v_reg, top_c_reg};
        stk_raddr  = VW'(depth_reg - NW'(2));
        stat.busy  = (state_reg != WK_IDLE);
        stat.done  = (state_reg == WK_DONE);
        stat.found = found_reg;
        case (state_reg)
            WK_IDLE:
            begin
                cnt_next = '0;
                if (check_go)
                begin
                    found_next = 1'b0;
                end
            end
            WK_HCLR:
            begin
                head_we  = 1'b1;
                cnt_next = (cnt_reg == NW'(MAX_VERTICES - 1)) ? '0 : cnt_reg + NW'(1);
            end
            WK_MCLR:
            begin
                if (cnt_reg >= n)
                begin
                    cnt_next = '0;
                end
                else
                begin
                    mark_we  = 1'b1;
                    cnt_next = cnt_reg + NW'(1);
                end
            end
            WK_START:
            begin
                // mark read of the candidate root is issued here
            end
            WK_SEEN:
            begin
                if (mark_rdata[1])
                begin
                    cnt_next = cnt_reg + NW'(1);
                end
                else
                begin
                    mark_we    = 1'b1;
                    mark_wdata = 2'b11;
                end
            end
            WK_ROOT:
            begin
                top_v_next = VW'(cnt_reg);
                top_c_next = head_rdata;
                depth_next = NW'(1);
            end
            WK_EDGE:
            begin
                if (top_nil)
                begin
                    // leaving the vertex: take it off the current path
                    mark_we    = 1'b1;
                    mark_waddr = top_v_reg;
                    mark_wdata = 2'b10;
                    depth_next = depth_reg - NW'(1);
                    if (depth_reg == NW'(1))
                    begin
                        cnt_next = cnt_reg + NW'(1);
                    end
                end
            end
            WK_ERD:
            begin
                top_c_next = e_link;
                t_next     = e_target;
                mark_raddr = e_target;
            end
            WK_MRD:
            begin
                head_raddr = t_reg;
                if (!mark_rdata[1])
                begin
                    if (depth_reg < NW'(MAX_VERTICES))
                    begin
                        mark_we    = 1'b1;
                        mark_waddr = t_reg;
                        mark_wdata = 2'b11;
                        stk_we     = 1'b1;
                    end
                end
                else if (mark_rdata[0])
                begin
                    found_next = 1'b1;
                end
            end
            WK_POP:
            begin
                top_v_next = stk_rdata[VW+EW-1:EW];
                top_c_next = stk_rdata[EW-1:0];
            end
            WK_PUSH:
            begin
                top_v_next = t_reg;
                top_c_next = head_rdata;
                depth_next = depth_reg + NW'(1);
            end
            WK_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= WK_HCLR;
            cnt_reg   <= '0;
            depth_reg <= '0;
            found_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            depth_reg <= depth_next;
            found_reg <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        top_v_reg <= top_v_next;
        top_c_reg <= top_c_next;
        t_reg     <= t_next;
    end

`ifndef SYNTHESIS
    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= NW'(MAX_VERTICES))
        else $error("search stack deeper than vertex store");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == WK_DONE |=> state_reg == WK_IDLE)
        else $error("result state held for more than one cycle");

    a_push_fresh: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == WK_PUSH |-> $past(state_reg) == WK_MRD && !$past(mark_rdata[1]))
        else $error("push of a vertex already seen");
`endif

endmodule
